// ===== rtl/mtcr_pkg.sv =====
`timescale 1ns / 1ps
package mtcr_pkg;

  // MIDI status and data byte codes
  localparam logic [7:0] BYTE_QF      = 8'hF1;
  localparam logic [7:0] BYTE_SOX     = 8'hF0;
  localparam logic [7:0] BYTE_EOX     = 8'hF7;
  localparam logic [7:0] ID_RT        = 8'h7F;
  localparam logic [7:0] ID_NRT       = 8'h7E;
  localparam logic [7:0] ID_MASK      = 8'hFE;
  localparam logic [7:0] SUB_FULL     = 8'h01;
  localparam logic [7:0] SUB_CUE      = 8'h00;
  localparam logic [7:0] CUE_EXIT_HI  = 8'h04;
  localparam logic [7:0] CUE_EXIT_LO  = 8'h00;
  localparam logic [7:0] RATE_FIELD   = 8'h60;

  localparam logic [2:0] RATE_CODE_25 = 3'd2;
  localparam logic [2:0] RATE_CODE_30 = 3'd6;
  localparam logic [4:0] FPS_25       = 5'd25;
  localparam logic [4:0] FPS_30       = 5'd30;

  localparam int BUF_DEPTH_DEF = 16;
  // Only the first eleven buffer entries are ever decoded
  localparam int BUF_REGS      = 11;
  localparam int SLOT_W        = 4;
  localparam int QF_PIECES     = 8;
  localparam logic [3:0] QF_CNT_MAX = 4'd15;
  localparam logic [3:0] QF_CNT_RUN = 4'd8;
  localparam logic [2:0] QF_LAST    = 3'd7;

  typedef enum logic [1:0] {
    EVT_QUARTER = 2'd0,
    EVT_FULL    = 2'd1,
    EVT_EXIT    = 2'd2
  } evt_kind_t;

  typedef enum logic {
    OP_QUARTER = 1'b0,
    OP_SYSEX   = 1'b1
  } op_kind_t;

  // Work item from front to back
  typedef struct packed {
    op_kind_t          kind;
    logic              store;  // write data into buffer slot
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
    logic              fire;   // quarter run complete / end of SysEx
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    evt_kind_t  kind;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
    logic [4:0] rate;
  } res_t;

endpackage

// ===== rtl/mtcr_front.sv =====
`timescale 1ns / 1ps
module mtcr_front #(
  parameter int BUF_DEPTH = mtcr_pkg::BUF_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic [7:0]     in_byte,
  output logic           push,
  output mtcr_pkg::op_t  push_op
);
  import mtcr_pkg::*;

  localparam int IDX_W = $clog2(BUF_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_QUARTER,
    MODE_FULL
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [3:0]       qcnt_r, qcnt_nxt;
  logic             accept;
  logic [2:0]       piece;
  logic [3:0]       qcnt_tmp;
  logic             idx_room;

  assign accept   = in_valid && in_ready;
  assign piece    = in_byte[6:4];
  assign idx_room = idx_r < IDX_W'(BUF_DEPTH);

  always_comb begin
    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    qcnt_nxt = qcnt_r;
    push     = 1'b0;
    push_op  = '0;
    qcnt_tmp = (piece == 3'd0) ? 4'd0 : qcnt_r;
    if (accept) begin
      if (in_byte == BYTE_QF) begin
        mode_nxt = MODE_QUARTER;
      end else if (in_byte == BYTE_SOX) begin
        mode_nxt = MODE_FULL;
        idx_nxt  = '0;
      end else begin
        case (mode_r)
          MODE_QUARTER: begin
            if (!in_byte[7]) begin
              if (qcnt_tmp < QF_CNT_MAX) qcnt_tmp = qcnt_tmp + 4'd1;
              qcnt_nxt      = qcnt_tmp;
              push          = 1'b1;
              push_op.kind  = OP_QUARTER;
              push_op.store = 1'b1;
              push_op.slot  = SLOT_W'(piece);
              push_op.data  = in_byte;
              push_op.fire  = (piece == QF_LAST) && (qcnt_tmp == QF_CNT_RUN);
            end
          end
          MODE_FULL: begin
            if (idx_r == '0 && (in_byte & ID_MASK) != ID_NRT) begin
              mode_nxt = MODE_NONE;
            end else begin
              if (idx_room) idx_nxt = idx_r + IDX_W'(1);
              push          = 1'b1;
              push_op.kind  = OP_SYSEX;
              push_op.store = idx_room && (idx_r < IDX_W'(BUF_REGS));
              push_op.slot  = idx_r[SLOT_W-1:0];
              push_op.data  = in_byte;
              push_op.fire  = (in_byte == BYTE_EOX);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      idx_r  <= '0;
      qcnt_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

endmodule

// ===== rtl/mtcr_fifo.sv =====
`timescale 1ns / 1ps
module mtcr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtcr_pkg::op_t     push_op,
  input  logic              pop,
  output mtcr_pkg::op_t     head_op,
  output mtcr_pkg::q_stat_t stat
);
  import mtcr_pkg::*;

  op_t        mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_op    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_op;
  end

endmodule

// ===== rtl/mtcr_back.sv =====
`timescale 1ns / 1ps
module mtcr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mtcr_pkg::op_t     head_op,
  input  mtcr_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output mtcr_pkg::res_t    res
);
  import mtcr_pkg::*;

  logic [7:0] buf_r [BUF_REGS];
  logic [7:0] view [BUF_REGS];
  logic [4:0] hours_r, hours_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [4:0] frm_r, frm_nxt;
  logic [4:0] rate_r, rate_nxt;
  logic       res_valid_r, res_valid_nxt;
  res_t       res_r, res_nxt;
  logic       emit;
  evt_kind_t  emit_kind;
  logic [2:0] rcode;
  logic [7:0] rt_rate;

  assign pop = !q_stat.empty && (!res_valid_r || res_ready);

  // buffer as seen after this op's write
  always_comb begin
    for (int i = 0; i < BUF_REGS; i++) begin
      view[i] = (head_op.store && head_op.slot == SLOT_W'(i)) ? head_op.data : buf_r[i];
    end
  end

  always_comb begin
    hours_nxt = hours_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frm_nxt   = frm_r;
    rate_nxt  = rate_r;
    emit      = 1'b0;
    emit_kind = EVT_QUARTER;
    rcode     = '0;
    rt_rate   = (view[4] & RATE_FIELD) >> 4;
    if (pop && head_op.fire) begin
      case (head_op.kind)
        OP_QUARTER: begin
          hours_nxt = {view[7][0], view[6][3:0]};
          min_nxt   = {view[5][1:0], view[4][3:0]};
          sec_nxt   = {view[3][1:0], view[2][3:0]};
          frm_nxt   = {view[1][0], view[0][3:0]};
          rcode     = view[7][2:0] & 3'b110;
          emit      = 1'b1;
          emit_kind = EVT_QUARTER;
        end
        OP_SYSEX: begin
          if (view[0] == ID_RT && view[3] == SUB_FULL) begin
            hours_nxt = view[4][4:0];
            min_nxt   = view[5][5:0];
            sec_nxt   = view[6][5:0];
            frm_nxt   = view[7][4:0];
            rcode     = rt_rate[2:0];
            emit      = 1'b1;
            emit_kind = EVT_FULL;
          end else if (view[0] == ID_NRT && view[3] == SUB_CUE &&
                       view[9] == CUE_EXIT_HI && view[10] == CUE_EXIT_LO) begin
            emit      = 1'b1;
            emit_kind = EVT_EXIT;
          end
        end
        default: ;
      endcase
      if (rcode == RATE_CODE_25) rate_nxt = FPS_25;
      else if (rcode == RATE_CODE_30) rate_nxt = FPS_30;
    end
    res_nxt         = res_r;
    res_nxt.kind    = emit_kind;
    res_nxt.hours   = hours_nxt;
    res_nxt.minutes = min_nxt;
    res_nxt.seconds = sec_nxt;
    res_nxt.frames  = frm_nxt;
    res_nxt.rate    = rate_nxt;
    if (emit) res_valid_nxt = 1'b1;
    else if (res_ready) res_valid_nxt = 1'b0;
    else res_valid_nxt = res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      hours_r     <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      frm_r       <= '0;
      rate_r      <= '0;
      for (int i = 0; i < BUF_REGS; i++) buf_r[i] <= '0;
    end else begin
      res_valid_r <= res_valid_nxt;
      hours_r     <= hours_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
      frm_r       <= frm_nxt;
      rate_r      <= rate_nxt;
      if (pop) begin
        for (int i = 0; i < BUF_REGS; i++) buf_r[i] <= view[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/midi_timecode_receiver_core.sv =====
`timescale 1ns / 1ps
// MIDI time code receiver. Takes one received MIDI byte per beat and tracks
// MTC: F1 enters quarter-frame mode, F0 enters SysEx full-frame mode. A run of
// eight quarter-frame pieces ending in piece 7 rebuilds the time and emits a
// quarter event; a 7F..01 full-frame message updates the time on F7; a 7E cue
// message with sub id 00 and bytes 9,10 = 04,00 emits an exit event. Every
// result carries the current hours/minutes/seconds/frames and frame rate
// (0 unknown, 25 or 30). Throughput is one byte per clock while the queue is
// not full: a front end tracks mode, SysEx index and quarter count, a two-entry
// queue hands decoded work to a back end that owns the byte buffer and time
// registers, and a result register feeds the output. A result passes through the
// queue entry and then the result register. Status bytes other than F0 and F1
// are ignored in quarter mode and the SysEx index saturates at BUF_DEPTH.
module midi_timecode_receiver_core #(
  parameter int BUF_DEPTH = mtcr_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                  // [21:17] frames, [26:22] frame_rate
  output logic [1:0]  out_tuser   // [1:0] event_kind
);
  import mtcr_pkg::*;

  logic    push;
  op_t     push_op;
  op_t     head_op;
  q_stat_t q_stat;
  logic    pop;
  res_t    res;

  // front stalls only on a full queue
  assign in_tready = !q_stat.full;

  mtcr_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .push     (push),
    .push_op  (push_op)
  );

  mtcr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  mtcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_op   (head_op),
    .q_stat    (q_stat),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {5'd0, res.rate, res.frames, res.seconds, res.minutes, res.hours};
  assign out_tuser = res.kind;

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a new result only follows a queue pop
  a_res_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(pop))
    else $error("result without work item");

  // exit carries no time change; kind 3 never appears
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("illegal event kind");

endmodule
